// ===== hdl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the band-pass biquad cascade
// Field widths, fixed-point formats, coefficient table and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // field widths
  localparam int ChanW   = 2;
  localparam int SampleW = 12;
  localparam int OutW    = 32;

  // defaults of the top level parameters
  localparam int DefChannels   = 3;
  localparam int DefSampleBits = 12;

  // fixed-point formats
  localparam int StW     = 40;  // Q24.16 state
  localparam int StFracW = 16;
  localparam int CoefW   = 28;  // Q3.25 coefficient
  localparam int FracW   = 25;
  localparam int MulBW   = 25;  // multiplier b operand: 24-bit high half or 16-bit low half
  localparam int ProdW   = CoefW + MulBW;
  localparam int AccW    = 70;  // running sum scaled by 2^25
  localparam int SumW    = AccW - FracW;

  localparam int Sections = 4;
  localparam int SecW     = $clog2(Sections);
  localparam int NumCoef  = 5;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [StW-1:0]   st_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // rounding offsets folded into the low bits of the accumulator
  localparam logic [FracW-1:0] BiasAdd = FracW'(1) << (FracW - 1);
  localparam logic [FracW-1:0] BiasSub = BiasAdd - FracW'(1);

  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};
  localparam st_t StMax = {1'b0, {(StW-1){1'b1}}};
  localparam st_t StMin = {1'b1, {(StW-1){1'b0}}};

  // decimal coefficients scaled by 1e8, rounded half away from zero into Q3.25
  localparam longint QOne  = 64'sd33554432;
  localparam longint QHalf = 64'sd50000000;
  localparam longint QDec  = 64'sd100000000;

  localparam coef_t CoefTab [Sections][NumCoef] = '{
    '{coef_t'(-((64'sd164891342 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd77932149  * QOne + QHalf) / QDec),
      coef_t'( (64'sd14412     * QOne + QHalf) / QDec),
      coef_t'( (64'sd28824     * QOne + QHalf) / QDec),
      coef_t'( (64'sd14412     * QOne + QHalf) / QDec)},
    '{coef_t'(-((64'sd175188517 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd82786889  * QOne + QHalf) / QDec),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec),
      coef_t'( (64'sd200000000 * QOne + QHalf) / QDec),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec)},
    '{coef_t'(-((64'sd169281282 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd88994696  * QOne + QHalf) / QDec),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec),
      coef_t'(-((64'sd200000000 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec)},
    '{coef_t'(-((64'sd188326655 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd93936089  * QOne + QHalf) / QDec),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec),
      coef_t'(-((64'sd200000000 * QOne + QHalf) / QDec)),
      coef_t'( (64'sd100000000 * QOne + QHalf) / QDec)}
  };

  typedef enum logic [2:0] {
    CO_A1,
    CO_A2,
    CO_B0,
    CO_B1,
    CO_B2
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_Z1,
    OPND_Z2,
    OPND_W
  } opnd_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOADV,
    ACC_ZERO,
    ACC_HI,
    ACC_LO
  } acc_op_e;

  typedef enum logic {
    ENT_Z1,
    ENT_Z2
  } ent_sel_e;

  typedef struct packed {
    logic            ld_in;
    logic [SecW-1:0] sec;
    logic            mem_rd;
    logic            mem_wr;
    ent_sel_e        ent;
    logic            ld_z1;
    logic            ld_z2;
    logic            mul_en;
    logic            mul_lo;
    coef_sel_e       coef;
    opnd_sel_e       opnd;
    acc_op_e         acc_op;
    logic            acc_sub;
    logic            ld_w;
    logic            ld_v;
    logic            out_ld;
    logic            out_zero;
  } bbc_cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic out_free;
  } bbc_sts_t;

  function automatic coef_t coef_lut(logic [SecW-1:0] sec, coef_sel_e sel);
    coef_t c;
    case (sel)
      CO_A1:   c = CoefTab[sec][0];
      CO_A2:   c = CoefTab[sec][1];
      CO_B0:   c = CoefTab[sec][2];
      CO_B1:   c = CoefTab[sec][3];
      CO_B2:   c = CoefTab[sec][4];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/bbc_ifs.sv =====
// ----------------------------------------------------------------------------
// bbc_ifs: sample and result channels
// Valid/ready channels carrying one raw sample in and one filtered value out.
// ----------------------------------------------------------------------------
interface bbc_in_if import bbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ChanW-1:0]   chan;
  logic [SampleW-1:0] sample;

  modport source (output valid, output chan, output sample, input ready);
  modport sink   (input valid, input chan, input sample, output ready);
endinterface

interface bbc_out_if import bbc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ChanW-1:0]       out_chan;
  logic signed [OutW-1:0] filtered;

  modport source (output valid, output out_chan, output filtered, input ready);
  modport sink   (input valid, input out_chan, input filtered, output ready);
endinterface

// ===== hdl/bbc_dpath.sv =====
// ----------------------------------------------------------------------------
// bbc_dpath: biquad datapath
// Delay word memory, shared 28x25 multiplier, rounding accumulator,
// saturation and the output register.
// ----------------------------------------------------------------------------
module bbc_dpath import bbc_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int SAMPLE_BITS = DefSampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ChanW-1:0]       chan_i,
  input  logic [SampleW-1:0]     sample_i,
  input  bbc_cmd_t               cmd_i,
  output bbc_sts_t               sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ChanW-1:0]       out_chan_o,
  output logic signed [OutW-1:0] filtered_o
);

  localparam int Depth = CHANNELS * Sections * 2;
  localparam int AddrW = $clog2(Depth);
  localparam logic [SampleW-1:0] SampleMask =
    (SAMPLE_BITS >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);

  // delay word memory, entries without a valid bit read as zero
  st_t              mem [Depth];
  logic [Depth-1:0] vld_q;
  st_t              rd_q;
  logic [AddrW-1:0] addr;
  st_t              wdata;

  logic [ChanW-1:0] chan_q;
  st_t              v_q, z1_q, z2_q, w_q;
  prod_t            mp_q;
  acc_t             acc_q, acc_d;
  coef_t            coef;
  st_t              opnd_z;
  logic signed [MulBW-1:0] opnd;
  acc_t             hi_ext, lo_ext, hi_base;
  logic signed [SumW-1:0] sum;
  st_t              sum_sat;

  logic                   out_valid_q;
  logic [ChanW-1:0]       out_chan_q;
  logic signed [OutW-1:0] filtered_q;
  logic signed [OutW-1:0] v_sat;

  assign sts_o.chan_ok  = (int'(chan_i) < CHANNELS);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign addr  = AddrW'({chan_q, cmd_i.sec, cmd_i.ent});
  assign wdata = (cmd_i.ent == ENT_Z2) ? z1_q : w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= vld_q[addr] ? mem[addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.mem_wr) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // multiplier operand: high half signed, low half as positive value
  always_comb begin
    case (cmd_i.opnd)
      OPND_Z1: opnd_z = z1_q;
      OPND_Z2: opnd_z = z2_q;
      default: opnd_z = w_q;
    endcase
  end

  assign coef = coef_lut(cmd_i.sec, cmd_i.coef);
  assign opnd = cmd_i.mul_lo ? {{(MulBW-StFracW){1'b0}}, opnd_z[StFracW-1:0]}
                             : {opnd_z[StW-1], opnd_z[StW-1:StFracW]};

  // accumulator keeps sum*2^25; each product is floored by clearing the low
  // bits before its rounding offset and high partial product go in
  assign hi_ext  = {{(AccW-ProdW-StFracW){mp_q[ProdW-1]}}, mp_q, {StFracW{1'b0}}};
  assign lo_ext  = {{(AccW-ProdW){mp_q[ProdW-1]}}, mp_q};
  assign hi_base = {acc_q[AccW-1:FracW], cmd_i.acc_sub ? BiasSub : BiasAdd};

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOADV: acc_d = {{(AccW-StW-FracW){v_q[StW-1]}}, v_q, {FracW{1'b0}}};
      ACC_ZERO:  acc_d = '0;
      ACC_HI:    acc_d = cmd_i.acc_sub ? hi_base - hi_ext : hi_base + hi_ext;
      ACC_LO:    acc_d = cmd_i.acc_sub ? acc_q - lo_ext : acc_q + lo_ext;
      default:   acc_d = acc_q;
    endcase
  end

  assign sum = acc_q[AccW-1:FracW];

  always_comb begin
    if (sum[SumW-1:StW-1] == {(SumW-StW+1){sum[SumW-1]}}) begin
      sum_sat = sum[StW-1:0];
    end else begin
      sum_sat = sum[SumW-1] ? StMin : StMax;
    end
  end

  always_comb begin
    if (v_q[StW-1:OutW-1] == {(StW-OutW+1){v_q[StW-1]}}) begin
      v_sat = v_q[OutW-1:0];
    end else begin
      v_sat = v_q[StW-1] ? OutMin : OutMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      chan_q <= chan_i;
      v_q    <= StW'({sample_i & SampleMask, {StFracW{1'b0}}});
    end else if (cmd_i.ld_v) begin
      v_q <= sum_sat;
    end
    if (cmd_i.ld_z1) begin
      z1_q <= rd_q;
    end
    if (cmd_i.ld_z2) begin
      z2_q <= rd_q;
    end
    if (cmd_i.ld_w) begin
      w_q <= sum_sat;
    end
    if (cmd_i.mul_en) begin
      mp_q <= coef * opnd;
    end
    acc_q <= acc_d;
    if (cmd_i.out_ld) begin
      out_chan_q <= chan_q;
      filtered_q <= cmd_i.out_zero ? '0 : v_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_chan_o  = out_chan_q;
  assign filtered_o  = filtered_q;

endmodule

// ===== hdl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl: biquad sequencer
// Steps the datapath through the two state reads, five products and two
// write-backs of each section, four sections per sample.
// ----------------------------------------------------------------------------
module bbc_ctrl import bbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bbc_sts_t sts_i,
  output bbc_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDZ1,
    ST_RDZ2,
    ST_W_A1H,
    ST_W_A1L,
    ST_W_A2H,
    ST_W_A2L,
    ST_W_FIN,
    ST_W_SAT,
    ST_Y_B0H,
    ST_Y_B0L,
    ST_Y_B1H,
    ST_Y_B1L,
    ST_Y_B2H,
    ST_Y_B2L,
    ST_Y_FIN,
    ST_Y_SAT,
    ST_DONE
  } state_e;

  localparam logic [SecW-1:0] SecLast = SecW'(Sections - 1);

  state_e          state_q, state_d;
  logic [SecW-1:0] sec_q, sec_d;
  logic            zero_q, zero_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      zero_q  <= zero_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sec_d      = sec_q;
    zero_d     = zero_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sec  = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          sec_d       = '0;
          zero_d      = !sts_i.chan_ok;
          state_d     = sts_i.chan_ok ? ST_RDZ1 : ST_DONE;
        end
      end
      ST_RDZ1: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.ent    = ENT_Z1;
        state_d      = ST_RDZ2;
      end
      ST_RDZ2: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.ent    = ENT_Z2;
        cmd_o.ld_z1  = 1'b1;
        state_d      = ST_W_A1H;
      end
      // w = v - a1*z1 - a2*z2
      ST_W_A1H: begin
        cmd_o.ld_z2  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.coef   = CO_A1;
        cmd_o.opnd   = OPND_Z1;
        cmd_o.acc_op = ACC_LOADV;
        state_d      = ST_W_A1L;
      end
      ST_W_A1L: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_lo  = 1'b1;
        cmd_o.coef    = CO_A1;
        cmd_o.opnd    = OPND_Z1;
        cmd_o.acc_op  = ACC_HI;
        cmd_o.acc_sub = 1'b1;
        state_d       = ST_W_A2H;
      end
      ST_W_A2H: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.coef    = CO_A2;
        cmd_o.opnd    = OPND_Z2;
        cmd_o.acc_op  = ACC_LO;
        cmd_o.acc_sub = 1'b1;
        state_d       = ST_W_A2L;
      end
      ST_W_A2L: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_lo  = 1'b1;
        cmd_o.coef    = CO_A2;
        cmd_o.opnd    = OPND_Z2;
        cmd_o.acc_op  = ACC_HI;
        cmd_o.acc_sub = 1'b1;
        state_d       = ST_W_FIN;
      end
      ST_W_FIN: begin
        cmd_o.acc_op  = ACC_LO;
        cmd_o.acc_sub = 1'b1;
        state_d       = ST_W_SAT;
      end
      // old z1 moves into the z2 entry
      ST_W_SAT: begin
        cmd_o.ld_w   = 1'b1;
        cmd_o.mem_wr = 1'b1;
        cmd_o.ent    = ENT_Z2;
        state_d      = ST_Y_B0H;
      end
      // y = b0*w + b1*z1 + b2*z2
      ST_Y_B0H: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.coef   = CO_B0;
        cmd_o.opnd   = OPND_W;
        cmd_o.acc_op = ACC_ZERO;
        state_d      = ST_Y_B0L;
      end
      ST_Y_B0L: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_lo = 1'b1;
        cmd_o.coef   = CO_B0;
        cmd_o.opnd   = OPND_W;
        cmd_o.acc_op = ACC_HI;
        state_d      = ST_Y_B1H;
      end
      ST_Y_B1H: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.coef   = CO_B1;
        cmd_o.opnd   = OPND_Z1;
        cmd_o.acc_op = ACC_LO;
        state_d      = ST_Y_B1L;
      end
      ST_Y_B1L: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_lo = 1'b1;
        cmd_o.coef   = CO_B1;
        cmd_o.opnd   = OPND_Z1;
        cmd_o.acc_op = ACC_HI;
        state_d      = ST_Y_B2H;
      end
      ST_Y_B2H: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.coef   = CO_B2;
        cmd_o.opnd   = OPND_Z2;
        cmd_o.acc_op = ACC_LO;
        state_d      = ST_Y_B2L;
      end
      ST_Y_B2L: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_lo = 1'b1;
        cmd_o.coef   = CO_B2;
        cmd_o.opnd   = OPND_Z2;
        cmd_o.acc_op = ACC_HI;
        state_d      = ST_Y_FIN;
      end
      ST_Y_FIN: begin
        cmd_o.acc_op = ACC_LO;
        state_d      = ST_Y_SAT;
      end
      // w goes into the z1 entry, y feeds the next section
      ST_Y_SAT: begin
        cmd_o.ld_v   = 1'b1;
        cmd_o.mem_wr = 1'b1;
        cmd_o.ent    = ENT_Z1;
        if (sec_q == SecLast) begin
          state_d = ST_DONE;
        end else begin
          sec_d   = sec_q + SecW'(1);
          state_d = ST_RDZ1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_zero = zero_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bandpass_biquad_cascade_core.sv =====
// ----------------------------------------------------------------------------
// bandpass_biquad_cascade_core: per-channel 8th-order band-pass filter
// Four direct-form-II biquad sections on one shared multiplier, with the
// delay words of every channel held in a small memory.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries a raw converter count and its channel; out_o returns the
//   filtered value in signed Q16.16 with the same channel number. each
//   transfer on in_i produces exactly one transfer on out_o, in order.
//   each section steps through two delay word reads, five products, each
//   taken as a high and a low half on the single 28x25 multiplier, two
//   accumulator settling steps and two write-backs. a new sample is taken
//   only once the previous one has passed all four sections, as the
//   multiplier is shared by all twenty products.
//   a channel number at or above CHANNELS gives a zero result and leaves
//   all filter state alone.
//   the result sits in an output register: the next sample is taken while it
//   waits, and the sequencer only holds at its last step if the previous
//   result is still not taken.
//   reset clears every channel's delay words at once (per-entry valid bits),
//   so samples are taken right after reset.
// ----------------------------------------------------------------------------
module bandpass_biquad_cascade_core import bbc_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int SAMPLE_BITS = DefSampleBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);

  bbc_cmd_t cmd;
  bbc_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbc_dpath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chan_i      (in_i.chan),
    .sample_i    (in_i.sample),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_chan_o  (out_o.out_chan),
    .filtered_o  (out_o.filtered)
  );

`ifndef SYNTHESIS
  // a bad channel never touches the delay memory
  a_bad_chan_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && !sts.chan_ok) |=> (!cmd.mem_rd && !cmd.mem_wr))
    else $error("delay memory accessed for an out-of-range channel");

  // a good channel starts with its z1 read
  a_good_chan_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && sts.chan_ok) |=> (cmd.mem_rd && cmd.ent == ENT_Z1))
    else $error("section sequence did not start after a sample transfer");

  // the output register is only overwritten once it is free
  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> sts.out_free)
    else $error("pending result overwritten");

  // no new sample while the multiplier is busy
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_en |-> !in_ready)
    else $error("sample taken while a filter pass is running");
`endif

endmodule

// ===== tb/bandpass_biquad_cascade_core_tb.sv =====
// ----------------------------------------------------------------------------
// bandpass_biquad_cascade_core_tb: self-checking bench of the band-pass core
// Drives raw samples on all channels, including the unused channel number,
// and compares every filtered result against a fixed-point model of the four
// biquad sections. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module bandpass_biquad_cascade_core_tb;
  import bbc_pkg::*;

  localparam int Channels   = DefChannels;
  localparam int NumSec     = 4;
  localparam int StallLimit = 4000;
  localparam int TailCycles = 80;
  localparam int RandItems  = 1700;

  typedef struct {
    logic [ChanW-1:0]       chan;
    logic signed [OutW-1:0] value;
  } filter_result_t;

  typedef enum int {
    SHAPE_CONST,
    SHAPE_SQUARE,
    SHAPE_NOISE,
    SHAPE_RAMP
  } shape_e;

  class biquad_tracker;
    longint         coef[NumSec][5];   // a1, a2, b0, b1, b2 in Q3.25
    longint         dly[Channels][NumSec][2];
    filter_result_t expected_q[$];
    int unsigned    mismatch_cnt;

    function new();
      longint dec [NumSec][5];
      dec = '{'{-164891342, 77932149, 14412, 28824, 14412},
              '{-175188517, 82786889, 100000000, 200000000, 100000000},
              '{-169281282, 88994696, 100000000, -200000000, 100000000},
              '{-188326655, 93936089, 100000000, -200000000, 100000000}};
      for (int s = 0; s < NumSec; s++) begin
        for (int k = 0; k < 5; k++) begin
          // round half away from zero
          if (dec[s][k] < 0) begin
            coef[s][k] = -((-dec[s][k] * 64'sd33554432 + 64'sd50000000) / 64'sd100000000);
          end else begin
            coef[s][k] = (dec[s][k] * 64'sd33554432 + 64'sd50000000) / 64'sd100000000;
          end
        end
      end
      for (int c = 0; c < Channels; c++) begin
        for (int s = 0; s < NumSec; s++) begin
          dly[c][s][0] = 0;
          dly[c][s][1] = 0;
        end
      end
      mismatch_cnt = 0;
    endfunction

    // Q3.25 times Q24.16, rounded to Q16 with ties toward +inf
    function longint round_prod(longint c, longint z);
      logic signed [95:0] pc;
      logic signed [95:0] pz;
      logic signed [95:0] p;
      pc = c;
      pz = z;
      p  = pc * pz + 96'sd16777216;
      return longint'(p >>> 25);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function logic signed [OutW-1:0] filter_sample(logic [ChanW-1:0] ch,
                                                   logic [SampleW-1:0] smp);
      longint st_hi;
      longint st_lo;
      longint v;
      longint w;
      longint y;
      longint z1;
      longint z2;
      st_hi = longint'(StMax);
      st_lo = longint'(StMin);
      if (ch >= Channels) return '0;
      v = longint'(smp) * 65536;
      for (int s = 0; s < NumSec; s++) begin
        z1 = dly[ch][s][0];
        z2 = dly[ch][s][1];
        w  = clamp(v - round_prod(coef[s][0], z1) - round_prod(coef[s][1], z2),
                   st_lo, st_hi);
        y  = round_prod(coef[s][2], w) + round_prod(coef[s][3], z1)
             + round_prod(coef[s][4], z2);
        v  = clamp(y, st_lo, st_hi);
        dly[ch][s][1] = z1;
        dly[ch][s][0] = w;
      end
      v = clamp(v, longint'(OutMin), longint'(OutMax));
      return v[OutW-1:0];
    endfunction

    function void note_sample(logic [ChanW-1:0] ch, logic [SampleW-1:0] smp);
      filter_result_t r;
      r.chan  = ch;
      r.value = filter_sample(ch, smp);
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_cnt++;
    endtask

    task check_result(logic [ChanW-1:0] ch, logic signed [OutW-1:0] val);
      filter_result_t r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result chan=%0d filtered=%0d", ch, val));
      end else begin
        r = expected_q.pop_front();
        if (ch !== r.chan) begin
          report_mismatch($sformatf("out_chan got %0d exp %0d", ch, r.chan));
        end
        if (val !== r.value) begin
          report_mismatch($sformatf("filtered chan=%0d got %0d exp %0d", r.chan, val,
                                    r.value));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bbc_in_if  smp_if ();
  bbc_out_if res_if ();

  bandpass_biquad_cascade_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if.sink),
    .out_o  (res_if.source)
  );

  biquad_tracker sb;
  bit            quiet;
  int            stall_left;
  int            idle_cycles;
  int            n_sent;

  always #6 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(40, 200);
  endfunction

  // result side: check each transfer, then decide ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.out_chan, res_if.filtered);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = idle_len();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic push_sample(input logic [ChanW-1:0] ch, input logic [SampleW-1:0] smp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.chan   <= ch;
    smp_if.sample <= smp;
    do @(posedge clk_i); while (!smp_if.ready);
    sb.note_sample(ch, smp);
    if (ch < Channels) n_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  task automatic run_burst(input logic [ChanW-1:0] ch, input shape_e shape, input int len);
    logic [SampleW-1:0] hi_lvl;
    logic [SampleW-1:0] lo_lvl;
    logic [SampleW-1:0] smp;
    logic [SampleW-1:0] step;
    int                 half;
    hi_lvl = ($urandom_range(0, 1) == 0) ? {SampleW{1'b1}} : SampleW'($urandom());
    lo_lvl = ($urandom_range(0, 1) == 0) ? '0 : SampleW'($urandom());
    half   = $urandom_range(1, 20);
    step   = SampleW'($urandom_range(1, 300));
    smp    = lo_lvl;
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_CONST:  smp = hi_lvl;
        SHAPE_SQUARE: smp = ((i / half) % 2 == 1) ? hi_lvl : lo_lvl;
        SHAPE_NOISE:  smp = SampleW'($urandom());
        default:      smp = smp + step;
      endcase
      // occasionally interleave another channel, the unused one included
      if ($urandom_range(0, 9) == 0) begin
        push_sample(ChanW'($urandom_range(0, 3)), SampleW'($urandom()));
      end
      push_sample(ch, smp);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    smp_if.valid  = 1'b0;
    smp_if.chan   = '0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    quiet         = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    n_sent        = 0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, channel isolation and the unused channel number
    push_sample(2'd0, 12'd0);
    push_sample(2'd0, 12'hfff);
    push_sample(2'd0, 12'hfff);
    push_sample(2'd0, 12'hfff);
    push_sample(2'd1, 12'hfff);
    push_sample(2'd1, 12'd0);
    push_sample(2'd1, 12'hfff);
    push_sample(2'd1, 12'd0);
    push_sample(2'd2, 12'h555);
    push_sample(2'd2, 12'haaa);
    push_sample(2'd3, 12'hfff);
    push_sample(2'd3, 12'd0);
    push_sample(2'd3, 12'h800);
    push_sample(2'd0, 12'd0);
    push_sample(2'd2, 12'hfff);
    push_sample(2'd0, 12'h001);
    push_sample(2'd1, 12'h800);
    push_sample(2'd2, 12'd0);
    push_sample(2'd0, 12'h7ff);
    push_sample(2'd3, 12'h123);
    drain_results();

    // random: mostly per-channel waveforms, some lone noise items
    n_sent = 0;
    while (n_sent < RandItems) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      if ($urandom_range(0, 19) == 0) begin
        push_sample(ChanW'($urandom_range(0, 3)), SampleW'($urandom()));
      end else begin
        run_burst(ChanW'($urandom_range(0, Channels - 1)),
                  shape_e'($urandom_range(0, 3)), $urandom_range(8, 40));
      end
      if ($urandom_range(0, 14) == 0) drain_results();
    end

    smp_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bbc_pkg.sv
hdl/bbc_ifs.sv
hdl/bbc_dpath.sv
hdl/bbc_ctrl.sv
hdl/bandpass_biquad_cascade_core.sv
tb/bandpass_biquad_cascade_core_tb.sv
